// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define V3_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");

// Clocked assertion that is also checked during reset.
`define V3_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

// File: rtl/v3alu_pkg.sv
// Package: operation codes, pipeline record and saturation helper for the vector ALU.
`timescale 1ns / 1ps
`default_nettype none
package v3alu_pkg;

    localparam int WORD_W = 32;
    localparam int SQRT_STAGES = 32;

    typedef enum logic [2:0] {
        OP_SUM   = 3'd0,
        OP_DIFF  = 3'd1,
        OP_NEG   = 3'd2,
        OP_SCALE = 3'd3,
        OP_DOT   = 3'd4,
        OP_CROSS = 3'd5,
        OP_MAG   = 3'd6,
        OP_NORM  = 3'd7
    } op_t;

    // Per-request record carried alongside the square root and divider
    typedef struct packed {
        op_t                op;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic signed [31:0] rs;
        logic               ovf;
    } info_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               ovf;
    } sat_t;

    localparam logic signed [65:0] WORD_MAX_W = 66'sh0_7FFF_FFFF;
    localparam logic signed [65:0] WORD_MIN_W = -66'sh0_8000_0000;

    // Clamp a wide signed value to the 32-bit word range
    function automatic sat_t sat_word(input logic signed [65:0] v);
        sat_t r;
        r.val = v[31:0];
        r.ovf = 1'b0;
        if (v > WORD_MAX_W) begin
            r.val = 32'sh7FFF_FFFF;
            r.ovf = 1'b1;
        end else if (v < WORD_MIN_W) begin
            r.val = 32'sh8000_0000;
            r.ovf = 1'b1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/vector3_fixed_point_alu.sv
// Top level: three-lane fixed-point 3-D vector ALU with merge, square root and normalize.
//
// Usage: a request on s_* carries op code, vectors A, B and a scale factor,
// all signed fixed point with FRAC_BITS fraction bits. One result comes back
// on m_* for every request, in order: res_x/y/z for vector ops, res_scalar
// for dot product and magnitude, overflow when any field saturated.
// Every op passes through the same registers from acceptance to m_valid:
// the lane and merge registers, 32 square root stages, FRAC_BITS + 1
// divider stages and the output register.
// Throughput is one request per cycle while the receiver does not stall; the whole pipeline advances as one.
// When the receiver stalls with a result held, the pipeline freezes and
// s_ready drops; bubbles in flight are not squeezed out.
// Reset (aresetn low, synchronous) empties the pipeline: all valid bits
// and m_valid clear, payload registers are left as they are.
`timescale 1ns / 1ps
`default_nettype none
module vector3_fixed_point_alu #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_req_type,
    input  wire logic signed [31:0] s_a_x,
    input  wire logic signed [31:0] s_a_y,
    input  wire logic signed [31:0] s_a_z,
    input  wire logic signed [31:0] s_b_x,
    input  wire logic signed [31:0] s_b_y,
    input  wire logic signed [31:0] s_b_z,
    input  wire logic signed [31:0] s_scale_factor,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_res_x,
    output logic signed [31:0]      m_res_y,
    output logic signed [31:0]      m_res_z,
    output logic signed [31:0]      m_res_scalar,
    output logic                    m_overflow
);
    import v3alu_pkg::*;

    localparam int DS   = FRAC_BITS + 1;
    localparam int LAST = SQRT_STAGES + DS;

    logic               adv;
    op_t                op_in;
    logic signed [63:0] px, py, pz;
    logic signed [64:0] vx, vy, vz;

    logic               v1_reg, v2_reg;
    op_t                op1_reg, op2_reg;
    logic signed [31:0] ax1_reg, ay1_reg, az1_reg, ax2_reg, ay2_reg, az2_reg;
    logic signed [65:0] sum_next, sum_reg;
    logic [63:0]        sq_reg;

    info_t              info_next;
    info_t              info_reg [LAST+1];
    logic               vld_reg  [LAST+1];
    logic [31:0]        mag;
    logic [31:0]        mag_reg  [DS];
    logic signed [31:0] qx, qy, qz;

    sat_t               sx, sy, sz, sd;

    logic signed [31:0] res_x_next, res_y_next, res_z_next, res_s_next;
    logic               ovf_next;
    logic               m_valid_reg;
    logic signed [31:0] res_x_reg, res_y_reg, res_z_reg, res_s_reg;
    logic               ovf_reg;

    // Whole pipeline moves when the output slot is free or being taken
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign op_in   = op_t'(s_req_type);

    // Element lanes
    v3alu_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .aclk(aclk), .en(adv), .op(op_in),
        .a_self(s_a_x), .b_self(s_b_x), .a_n1(s_a_y), .b_n1(s_b_y),
        .a_n2(s_a_z), .b_n2(s_b_z), .scale(s_scale_factor),
        .prod_out(px), .val_out(vx)
    );
    v3alu_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .aclk(aclk), .en(adv), .op(op_in),
        .a_self(s_a_y), .b_self(s_b_y), .a_n1(s_a_z), .b_n1(s_b_z),
        .a_n2(s_a_x), .b_n2(s_b_x), .scale(s_scale_factor),
        .prod_out(py), .val_out(vy)
    );
    v3alu_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
        .aclk(aclk), .en(adv), .op(op_in),
        .a_self(s_a_z), .b_self(s_b_z), .a_n1(s_a_x), .b_n1(s_b_x),
        .a_n2(s_a_y), .b_n2(s_b_y), .scale(s_scale_factor),
        .prod_out(pz), .val_out(vz)
    );

    // Side-band payload for lane stages 1 and 2
    always_ff @(posedge aclk) begin
        if (adv) begin
            op1_reg <= op_in;
            ax1_reg <= s_a_x;
            ay1_reg <= s_a_y;
            az1_reg <= s_a_z;
            op2_reg <= op1_reg;
            ax2_reg <= ax1_reg;
            ay2_reg <= ay1_reg;
            az2_reg <= az1_reg;
            sum_reg <= sum_next;
        end
    end

    // Merge: dot product and sum of squares share one adder
    assign sum_next = 66'(px) + 66'(py) + 66'(pz);

    // Merge stage: saturate lane results and the dot product
    always_comb begin
        sx = sat_word(66'(vx));
        sy = sat_word(66'(vy));
        sz = sat_word(66'(vz));
        sd = sat_word(sum_reg >>> FRAC_BITS);
        info_next.op  = op2_reg;
        info_next.ax  = ax2_reg;
        info_next.ay  = ay2_reg;
        info_next.az  = az2_reg;
        info_next.rx  = sx.val;
        info_next.ry  = sy.val;
        info_next.rz  = sz.val;
        info_next.rs  = '0;
        info_next.ovf = sx.ovf | sy.ovf | sz.ovf;
        if (op2_reg == OP_DOT) begin
            info_next.rs  = sd.val;
            info_next.ovf = sd.ovf;
        end
    end

    // Request record delay line, aligned with square root and divider
    always_ff @(posedge aclk) begin
        if (adv) begin
            info_reg[0] <= info_next;
            sq_reg      <= sum_reg[63:0];
            for (int i = 1; i <= LAST; i++) begin
                info_reg[i] <= info_reg[i-1];
            end
            mag_reg[0] <= mag;
            for (int i = 1; i < DS; i++) begin
                mag_reg[i] <= mag_reg[i-1];
            end
        end
    end

    v3alu_sqrt u_sqrt (
        .aclk(aclk), .en(adv), .radicand(sq_reg), .root(mag)
    );

    // Normalize dividers, one per element
    v3alu_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .aclk(aclk), .en(adv), .a(info_reg[SQRT_STAGES].ax), .mag(mag), .quot(qx)
    );
    v3alu_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .aclk(aclk), .en(adv), .a(info_reg[SQRT_STAGES].ay), .mag(mag), .quot(qy)
    );
    v3alu_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
        .aclk(aclk), .en(adv), .a(info_reg[SQRT_STAGES].az), .mag(mag), .quot(qz)
    );

    // Valid bits for every stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int i = 0; i <= LAST; i++) begin
                vld_reg[i] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg     <= s_valid;
            v2_reg     <= v1_reg;
            vld_reg[0] <= v2_reg;
            for (int i = 1; i <= LAST; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
            m_valid_reg <= vld_reg[LAST];
        end
    end

    // Final select: magnitude and normalize results join here
    always_comb begin
        res_x_next = info_reg[LAST].rx;
        res_y_next = info_reg[LAST].ry;
        res_z_next = info_reg[LAST].rz;
        res_s_next = info_reg[LAST].rs;
        ovf_next   = info_reg[LAST].ovf;
        unique case (info_reg[LAST].op)
            OP_MAG: begin
                res_s_next = mag_reg[DS-1][31] ? 32'sh7FFF_FFFF : $signed(mag_reg[DS-1]);
                ovf_next   = mag_reg[DS-1][31];
            end
            OP_NORM: begin
                ovf_next = 1'b0;
                if (mag_reg[DS-1] == '0) begin
                    res_x_next = info_reg[LAST].ax;
                    res_y_next = info_reg[LAST].ay;
                    res_z_next = info_reg[LAST].az;
                end else begin
                    res_x_next = qx;
                    res_y_next = qy;
                    res_z_next = qz;
                end
            end
            default: begin
                ovf_next = info_reg[LAST].ovf;
            end
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (adv) begin
            res_x_reg <= res_x_next;
            res_y_reg <= res_y_next;
            res_z_reg <= res_z_next;
            res_s_reg <= res_s_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_res_x      = res_x_reg;
    assign m_res_y      = res_y_reg;
    assign m_res_z      = res_z_reg;
    assign m_res_scalar = res_s_reg;
    assign m_overflow   = ovf_reg;

endmodule
`default_nettype wire

// File: rtl/v3alu_lane.sv
// One vector element lane: multipliers, add/subtract and per-element result.
`timescale 1ns / 1ps
`default_nettype none
module v3alu_lane #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                aclk,
    input  wire logic                en,
    input  wire v3alu_pkg::op_t      op,
    input  wire logic signed [31:0]  a_self,
    input  wire logic signed [31:0]  b_self,
    input  wire logic signed [31:0]  a_n1,
    input  wire logic signed [31:0]  b_n1,
    input  wire logic signed [31:0]  a_n2,
    input  wire logic signed [31:0]  b_n2,
    input  wire logic signed [31:0]  scale,
    output logic signed [63:0]       prod_out,
    output logic signed [64:0]       val_out
);
    import v3alu_pkg::*;

    logic signed [31:0] m0a, m0b, m1a, m1b;
    logic signed [63:0] p0_next, p1_next, p0_reg, p1_reg;
    logic signed [32:0] as_next, as_reg;
    op_t                op_reg;
    logic signed [64:0] diff;
    logic signed [64:0] val_next, val_reg;

    // Operand select for the two multipliers
    always_comb begin
        m0a = '0;
        m0b = '0;
        m1a = '0;
        m1b = '0;
        unique case (op)
            OP_SCALE: begin
                m0a = a_self;
                m0b = scale;
            end
            OP_DOT: begin
                m0a = a_self;
                m0b = b_self;
            end
            OP_CROSS: begin
                m0a = a_n1;
                m0b = b_n2;
                m1a = a_n2;
                m1b = b_n1;
            end
            OP_MAG, OP_NORM: begin
                m0a = a_self;
                m0b = a_self;
            end
            default: begin
                m0a = '0;
            end
        endcase
    end

    assign p0_next = m0a * m0b;
    assign p1_next = m1a * m1b;

    // Element-wise add, subtract, negate
    always_comb begin
        unique case (op)
            OP_SUM:  as_next = {a_self[31], a_self} + {b_self[31], b_self};
            OP_DIFF: as_next = {a_self[31], a_self} - {b_self[31], b_self};
            OP_NEG:  as_next = -{a_self[31], a_self};
            default: as_next = '0;
        endcase
    end

    // Stage 1: products and add/subtract results
    always_ff @(posedge aclk) begin
        if (en) begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            as_reg <= as_next;
            op_reg <= op;
        end
    end

    assign diff = {p0_reg[63], p0_reg} - {p1_reg[63], p1_reg};

    // Stage 2: rounded element result (floor shift)
    always_comb begin
        unique case (op_reg)
            OP_SUM, OP_DIFF, OP_NEG: val_next = 65'(as_reg);
            OP_SCALE: val_next = $signed({p0_reg[63], p0_reg}) >>> FRAC_BITS;
            OP_CROSS: val_next = diff >>> FRAC_BITS;
            default:  val_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            val_reg <= val_next;
        end
    end

    assign prod_out = p0_reg;
    assign val_out  = val_reg;

endmodule
`default_nettype wire

// File: rtl/v3alu_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module v3alu_sqrt (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [63:0] radicand,
    output logic [31:0]      root
);
    import v3alu_pkg::*;

    logic [63:0] rem_reg  [SQRT_STAGES];
    logic [31:0] root_reg [SQRT_STAGES];

    genvar s;
    generate
        for (s = 0; s < SQRT_STAGES; s++) begin : g_stage
            localparam int K = SQRT_STAGES - 1 - s;
            logic [63:0] rem_in;
            logic [31:0] root_in;
            logic [65:0] trial;
            logic        ge;

            if (s == 0) begin : g_first
                assign rem_in  = radicand;
                assign root_in = '0;
            end else begin : g_next
                assign rem_in  = rem_reg[s-1];
                assign root_in = root_reg[s-1];
            end

            // Try setting bit K of the root: (R + 2^K)^2 - R^2 = 2*R*2^K + 2^(2K)
            assign trial = (66'(root_in) << (2 * K + 2)) + (66'(1) << (2 * K));
            assign ge    = {2'b00, rem_in} >= trial;

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s]  <= ge ? rem_in - trial[63:0] : rem_in;
                    root_reg[s] <= {root_in[30:0], ge};
                end
            end
        end
    endgenerate

    assign root = root_reg[SQRT_STAGES-1];

endmodule
`default_nettype wire

// File: rtl/v3alu_div.sv
// Pipelined restoring divider for one normalize lane: (a << FRAC_BITS) / mag.
`timescale 1ns / 1ps
`default_nettype none
module v3alu_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic signed [31:0] a,
    input  wire logic [31:0]        mag,
    output logic signed [31:0]      quot
);
    localparam int DS = FRAC_BITS + 1;
    localparam int RW = 32 + FRAC_BITS;
    localparam int QW = FRAC_BITS + 1;

    logic [RW-1:0] rem_reg [DS];
    logic [QW-1:0] q_reg   [DS];
    logic [31:0]   mag_reg [DS];
    logic          neg_reg [DS];
    logic [31:0]   abs_a;

    assign abs_a = a[31] ? 32'(-a) : 32'(a);

    genvar s;
    generate
        for (s = 0; s < DS; s++) begin : g_stage
            localparam int J = FRAC_BITS - s;
            logic [RW-1:0] rem_in;
            logic [QW-1:0] q_in;
            logic [31:0]   mag_in;
            logic          neg_in;
            logic [RW:0]   dsh;
            logic          ge;
            logic [QW-1:0] q_next;

            if (s == 0) begin : g_first
                assign rem_in = RW'(abs_a) << FRAC_BITS;
                assign q_in   = '0;
                assign mag_in = mag;
                assign neg_in = a[31];
            end else begin : g_next
                assign rem_in = rem_reg[s-1];
                assign q_in   = q_reg[s-1];
                assign mag_in = mag_reg[s-1];
                assign neg_in = neg_reg[s-1];
            end

            // Compare against the shifted divisor, set quotient bit J
            assign dsh = (RW+1)'(mag_in) << J;
            assign ge  = {1'b0, rem_in} >= dsh;

            always_comb begin
                q_next = q_in;
                q_next[J] = ge;
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s] <= ge ? rem_in - dsh[RW-1:0] : rem_in;
                    q_reg[s]   <= q_next;
                    mag_reg[s] <= mag_in;
                    neg_reg[s] <= neg_in;
                end
            end
        end
    endgenerate

    // Truncation toward zero: apply the sign to the magnitude quotient
    assign quot = neg_reg[DS-1] ? -(32'(q_reg[DS-1])) : 32'(q_reg[DS-1]);

endmodule
`default_nettype wire

// File: rtl/v3alu_checker.sv
// Port-level checker for the vector ALU, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module v3alu_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [31:0] m_res_x,
    input wire logic signed [31:0] m_res_y,
    input wire logic signed [31:0] m_res_z,
    input wire logic signed [31:0] m_res_scalar,
    input wire logic               m_overflow
);
    // A stalled result holds
    `V3_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_res_x) && $stable(m_res_y) && $stable(m_res_z) && $stable(m_res_scalar) && $stable(m_overflow))
    // Reset empties the output slot
    `V3_ASSERT_ALWAYS(a_rst_empty, aclk, !aresetn |=> !m_valid)
    // An empty output slot never blocks requests
    `V3_ASSERT(a_ready_empty, aclk, aresetn, !m_valid |-> s_ready)
    // A taken result frees the input side in the same cycle
    `V3_ASSERT(a_ready_drain, aclk, aresetn, m_ready |-> s_ready)
endmodule

bind vector3_fixed_point_alu v3alu_checker u_v3alu_checker (.*);
`default_nettype wire
